>>> sv/gdate_pkg.sv
// package for the gregorian date add/subtract block: types, constants, microcode rom
package gdate_pkg;

  // field widths fixed by the interface
  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int MODE_W  = 2;
  localparam int MOD_W   = 9;   // year modulo 400
  localparam int PC_W    = 4;

  // parameter defaults
  localparam int OFFSET_BITS_DEF = 16;
  localparam int MAX_YEAR_DEF    = 9999;

  // mode codes
  localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADD  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SUB  = 2'd2;

  // month numbers and the four-century cycle
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [MOD_W-1:0]   MOD_TOP   = 9'd399;
  localparam logic [MOD_W-1:0]   CENT_1    = 9'd100;
  localparam logic [MOD_W-1:0]   CENT_2    = 9'd200;
  localparam logic [MOD_W-1:0]   CENT_3    = 9'd300;
  localparam logic [YEAR_W-1:0]  YEARS_400 = 14'd400;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_INIT,
    OP_ADD_STEP,
    OP_SUB_STEP,
    OP_SUB400,
    OP_LOAD_DAY,
    OP_FIN_COMMIT,
    OP_FIN_HOLD,
    OP_FIN_OVF
  } op_t;

  // jump conditions
  typedef enum logic [3:0] {
    C_NEVER,
    C_IS_LOAD,
    C_IS_ADD,
    C_IS_SUB,
    C_ADD_EXIT,
    C_OVF,
    C_SUB_EXIT,
    C_SUB_FITS,
    C_MOD_LT400
  } cond_t;

  // control word: op runs when the jump is not taken, then pc goes to next
  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] jump;
    logic [PC_W-1:0] next;
  } uword_t;

  // step addresses
  localparam logic [PC_W-1:0] S_INIT     = 4'd0;
  localparam logic [PC_W-1:0] S_DISP_LD  = 4'd1;
  localparam logic [PC_W-1:0] S_DISP_ADD = 4'd2;
  localparam logic [PC_W-1:0] S_DISP_SUB = 4'd3;
  localparam logic [PC_W-1:0] S_ADD_LOOP = 4'd4;
  localparam logic [PC_W-1:0] S_ADD_END  = 4'd5;
  localparam logic [PC_W-1:0] S_SUB_LOOP = 4'd6;
  localparam logic [PC_W-1:0] S_SUB_END  = 4'd7;
  localparam logic [PC_W-1:0] S_COMMIT   = 4'd8;
  localparam logic [PC_W-1:0] S_OVF      = 4'd9;
  localparam logic [PC_W-1:0] S_LD_MOD   = 4'd10;
  localparam logic [PC_W-1:0] S_LD_DAY   = 4'd11;

  // microcode rom
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{op: OP_FIN_HOLD, cond: C_NEVER, jump: S_INIT, next: S_INIT};
    unique case (pc)
      S_INIT:     w = '{op: OP_INIT,       cond: C_NEVER,     jump: S_INIT,    next: S_DISP_LD};
      S_DISP_LD:  w = '{op: OP_NOP,        cond: C_IS_LOAD,   jump: S_LD_MOD,  next: S_DISP_ADD};
      S_DISP_ADD: w = '{op: OP_NOP,        cond: C_IS_ADD,    jump: S_ADD_LOOP, next: S_DISP_SUB};
      S_DISP_SUB: w = '{op: OP_FIN_HOLD,   cond: C_IS_SUB,    jump: S_SUB_LOOP, next: S_INIT};
      S_ADD_LOOP: w = '{op: OP_ADD_STEP,   cond: C_ADD_EXIT,  jump: S_ADD_END, next: S_ADD_LOOP};
      S_ADD_END:  w = '{op: OP_FIN_COMMIT, cond: C_OVF,       jump: S_OVF,     next: S_INIT};
      S_SUB_LOOP: w = '{op: OP_SUB_STEP,   cond: C_SUB_EXIT,  jump: S_SUB_END, next: S_SUB_LOOP};
      S_SUB_END:  w = '{op: OP_FIN_OVF,    cond: C_SUB_FITS,  jump: S_COMMIT,  next: S_INIT};
      S_COMMIT:   w = '{op: OP_FIN_COMMIT, cond: C_NEVER,     jump: S_INIT,    next: S_INIT};
      S_OVF:      w = '{op: OP_FIN_OVF,    cond: C_NEVER,     jump: S_INIT,    next: S_INIT};
      S_LD_MOD:   w = '{op: OP_SUB400,     cond: C_MOD_LT400, jump: S_LD_DAY,  next: S_LD_MOD};
      S_LD_DAY:   w = '{op: OP_LOAD_DAY,   cond: C_NEVER,     jump: S_INIT,    next: S_COMMIT};
      default:    w = '{op: OP_FIN_HOLD,   cond: C_NEVER,     jump: S_INIT,    next: S_INIT};
    endcase
    return w;
  endfunction

  // leap year from the two low year bits and the year modulo 400
  function automatic logic leap_of(input logic [1:0] ylo, input logic [MOD_W-1:0] m400);
    logic cent;
    cent = (m400 == CENT_1) || (m400 == CENT_2) || (m400 == CENT_3);
    return (m400 == '0) || ((ylo == 2'b00) && !cent);
  endfunction

  // month length, february stretched in leap years
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic lp);
    logic [DAY_W-1:0] d;
    unique case (m)
      4'd2:                      d = lp ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

>>> sv/gregorian_date_add_subtract_days_top.sv
// gregorian date register with load, add days and subtract days, microcoded
//
//   channel | signals                                          | direction
//   --------+--------------------------------------------------+----------
//   in      | in_valid in_ready mode load_day load_month        | into block
//           | load_year offset_days                            |
//   out     | out_valid out_ready cur_day cur_month cur_year    | out of block
//           | is_leap overflow                                 |
//
// the month loops do one month per cycle, add and subtract each through its own
// month-length lookup and adder.
// rst (synchronous) sets the date to 1 january of year 1 and empties the output.
// in_ready is low while an item is being worked; the next item is taken while a
// result waits, and the final step holds until the output register is free.
module gregorian_date_add_subtract_days_top #(
  parameter int OFFSET_BITS = gdate_pkg::OFFSET_BITS_DEF,
  parameter int MAX_YEAR    = gdate_pkg::MAX_YEAR_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [gdate_pkg::MODE_W-1:0]  mode,
  input  logic [gdate_pkg::DAY_W-1:0]   load_day,
  input  logic [gdate_pkg::MONTH_W-1:0] load_month,
  input  logic [gdate_pkg::YEAR_W-1:0]  load_year,
  input  logic [OFFSET_BITS-1:0]       offset_days,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [gdate_pkg::DAY_W-1:0]   cur_day,
  output logic [gdate_pkg::MONTH_W-1:0] cur_month,
  output logic [gdate_pkg::YEAR_W-1:0]  cur_year,
  output logic                         is_leap,
  output logic                         overflow
);
  import gdate_pkg::*;

  localparam int REM_W = OFFSET_BITS + 2;
  localparam logic [YEAR_W-1:0] MaxYear = YEAR_W'(MAX_YEAR);
  localparam logic [YEAR_W-1:0] YearOne = 14'd1;
  localparam logic signed [REM_W-1:0] RemOne = REM_W'(1);

  // held date
  logic [DAY_W-1:0]   day_reg;
  logic [MONTH_W-1:0] month_reg;
  logic [YEAR_W-1:0]  year_reg;
  logic [MOD_W-1:0]   mod_reg;

  // latched item
  logic [MODE_W-1:0]      mode_q;
  logic [DAY_W-1:0]       load_day_q;
  logic [MONTH_W-1:0]     load_month_q;
  logic [YEAR_W-1:0]      load_year_q;
  logic [OFFSET_BITS-1:0] off_q;

  // working registers
  logic signed [REM_W-1:0] w_rem;
  logic [MONTH_W-1:0]      w_m;
  logic [YEAR_W-1:0]       w_y;
  logic [YEAR_W-1:0]       w_mod;
  logic                    w_ovf;

  // sequencer
  logic            busy, busy_next;
  logic [PC_W-1:0] pc, pc_next;
  uword_t          uw;
  logic            cond_true;
  logic            is_fin;
  logic            fin_stall;
  logic            exec;

  // datapath helpers
  logic                    w_leap;
  logic [DAY_W-1:0]        w_dim;
  logic signed [REM_W-1:0] w_dim_ext;
  logic [MONTH_W-1:0]      m_dec;
  logic [YEAR_W-1:0]       y_dec;
  logic [MOD_W-1:0]        mod_dec;
  logic [DAY_W-1:0]        dim_dec;
  logic signed [REM_W-1:0] dim_dec_ext;
  logic [MONTH_W-1:0]      m_inc;
  logic [YEAR_W-1:0]       y_inc;
  logic [MOD_W-1:0]        mod_inc;
  logic                    sub_under;
  logic [MONTH_W-1:0]      ld_month_sat;
  logic [YEAR_W-1:0]       ld_year_sat;

  assign in_ready = !busy;

  // month length of the working date
  always_comb begin
    w_leap    = leap_of(w_y[1:0], w_mod[MOD_W-1:0]);
    w_dim     = month_days(w_m, w_leap);
    w_dim_ext = REM_W'(w_dim);
  end

  // one month forward
  always_comb begin
    if (w_m == MONTH_DEC) begin
      m_inc   = MONTH_JAN;
      y_inc   = w_y + YearOne;
      mod_inc = (w_mod[MOD_W-1:0] == MOD_TOP) ? '0 : w_mod[MOD_W-1:0] + 9'd1;
    end else begin
      m_inc   = w_m + 4'd1;
      y_inc   = w_y;
      mod_inc = w_mod[MOD_W-1:0];
    end
  end

  // one month back, with the length of the month stepped into
  always_comb begin
    if (w_m == MONTH_JAN) begin
      m_dec   = MONTH_DEC;
      y_dec   = w_y - YearOne;
      mod_dec = (w_mod[MOD_W-1:0] == '0) ? MOD_TOP : w_mod[MOD_W-1:0] - 9'd1;
    end else begin
      m_dec   = w_m - 4'd1;
      y_dec   = w_y;
      mod_dec = w_mod[MOD_W-1:0];
    end
    dim_dec     = month_days(m_dec, leap_of(y_dec[1:0], mod_dec));
    dim_dec_ext = REM_W'(dim_dec);
    sub_under   = (w_m == MONTH_JAN) && (w_y <= YearOne);
  end

  // load field saturation
  always_comb begin
    if (load_month_q == '0) begin
      ld_month_sat = MONTH_JAN;
    end else if (load_month_q > MONTH_DEC) begin
      ld_month_sat = MONTH_DEC;
    end else begin
      ld_month_sat = load_month_q;
    end
    if (load_year_q == '0) begin
      ld_year_sat = YearOne;
    end else if (load_year_q > MaxYear) begin
      ld_year_sat = MaxYear;
    end else begin
      ld_year_sat = load_year_q;
    end
  end

  // condition select
  always_comb begin
    uw = ucode(pc);
    unique case (uw.cond)
      C_NEVER:     cond_true = 1'b0;
      C_IS_LOAD:   cond_true = (mode_q == MODE_LOAD);
      C_IS_ADD:    cond_true = (mode_q == MODE_ADD);
      C_IS_SUB:    cond_true = (mode_q == MODE_SUB);
      C_ADD_EXIT:  cond_true = w_ovf || (w_rem <= w_dim_ext);
      C_OVF:       cond_true = w_ovf;
      C_SUB_EXIT:  cond_true = (w_rem >= RemOne) || sub_under;
      C_SUB_FITS:  cond_true = (w_rem >= RemOne);
      C_MOD_LT400: cond_true = (w_mod < YEARS_400);
      default:     cond_true = 1'b0;
    endcase
  end

  // step counter and busy flag
  always_comb begin
    is_fin    = (uw.op == OP_FIN_COMMIT) || (uw.op == OP_FIN_HOLD) ||
                (uw.op == OP_FIN_OVF);
    fin_stall = is_fin && !cond_true && out_valid && !out_ready;
    exec      = busy && !cond_true && !fin_stall;
    pc_next   = pc;
    busy_next = busy;
    if (busy && !fin_stall) begin
      pc_next = cond_true ? uw.jump : uw.next;
      if (exec && is_fin) begin
        busy_next = 1'b0;
      end
    end else if (!busy && in_valid) begin
      pc_next   = S_INIT;
      busy_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= S_INIT;
    end else begin
      busy <= busy_next;
      pc   <= pc_next;
    end
  end

  // item latch
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode_q       <= mode;
      load_day_q   <= load_day;
      load_month_q <= load_month;
      load_year_q  <= load_year;
      off_q        <= offset_days;
    end
  end

  // working datapath
  always_ff @(posedge clk) begin
    if (exec) begin
      unique case (uw.op)
        OP_INIT: begin
          w_ovf <= 1'b0;
          if (mode_q == MODE_LOAD) begin
            w_m   <= ld_month_sat;
            w_y   <= ld_year_sat;
            w_mod <= ld_year_sat;
          end else begin
            w_m   <= month_reg;
            w_y   <= year_reg;
            w_mod <= YEAR_W'(mod_reg);
            if (mode_q == MODE_SUB) begin
              w_rem <= REM_W'(day_reg) - REM_W'(off_q);
            end else begin
              w_rem <= REM_W'(day_reg) + REM_W'(off_q);
            end
          end
        end
        OP_ADD_STEP: begin
          w_rem <= w_rem - w_dim_ext;
          w_m   <= m_inc;
          if ((w_m == MONTH_DEC) && (w_y == MaxYear)) begin
            w_ovf <= 1'b1;
          end else begin
            w_y   <= y_inc;
            w_mod <= YEAR_W'(mod_inc);
          end
        end
        OP_SUB_STEP: begin
          w_rem <= w_rem + dim_dec_ext;
          w_m   <= m_dec;
          w_y   <= y_dec;
          w_mod <= YEAR_W'(mod_dec);
        end
        OP_SUB400: begin
          w_mod <= w_mod - YEARS_400;
        end
        OP_LOAD_DAY: begin
          if (load_day_q == '0) begin
            w_rem <= RemOne;
          end else if (load_day_q > w_dim) begin
            w_rem <= w_dim_ext;
          end else begin
            w_rem <= REM_W'(load_day_q);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // held date update
  always_ff @(posedge clk) begin
    if (rst) begin
      day_reg   <= DAY_W'(1);
      month_reg <= MONTH_JAN;
      year_reg  <= YearOne;
      mod_reg   <= MOD_W'(1);
    end else if (exec && (uw.op == OP_FIN_COMMIT)) begin
      day_reg   <= w_rem[DAY_W-1:0];
      month_reg <= w_m;
      year_reg  <= w_y;
      mod_reg   <= w_mod[MOD_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec && is_fin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec && is_fin) begin
      if (uw.op == OP_FIN_COMMIT) begin
        cur_day   <= w_rem[DAY_W-1:0];
        cur_month <= w_m;
        cur_year  <= w_y;
        is_leap   <= w_leap;
        overflow  <= 1'b0;
      end else begin
        cur_day   <= day_reg;
        cur_month <= month_reg;
        cur_year  <= year_reg;
        is_leap   <= leap_of(year_reg[1:0], mod_reg);
        overflow  <= (uw.op == OP_FIN_OVF);
      end
    end
  end

endmodule

>>> verif/gregorian_date_add_subtract_days_chk.sv
// checker for the gregorian date block: predicts each result date and compares it on arrival
`timescale 1ns / 1ps

module gregorian_date_add_subtract_days_chk (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic                                  in_ready,
  input  logic [gdate_pkg::MODE_W-1:0]          mode,
  input  logic [gdate_pkg::DAY_W-1:0]           load_day,
  input  logic [gdate_pkg::MONTH_W-1:0]         load_month,
  input  logic [gdate_pkg::YEAR_W-1:0]          load_year,
  input  logic [gdate_pkg::OFFSET_BITS_DEF-1:0] offset_days,
  input  logic                                  out_valid,
  input  logic                                  out_ready,
  input  logic [gdate_pkg::DAY_W-1:0]           cur_day,
  input  logic [gdate_pkg::MONTH_W-1:0]         cur_month,
  input  logic [gdate_pkg::YEAR_W-1:0]          cur_year,
  input  logic                                  is_leap,
  input  logic                                  overflow,
  output int                                    fail_count,
  output int                                    pending
);

  localparam int LAST_YEAR = gdate_pkg::MAX_YEAR_DEF;

  typedef struct packed {
    logic [gdate_pkg::DAY_W-1:0]   day;
    logic [gdate_pkg::MONTH_W-1:0] month;
    logic [gdate_pkg::YEAR_W-1:0]  year;
    logic                          leap;
    logic                          ovf;
  } date_res_t;

  date_res_t expected_dates[$];
  int        held_day;
  int        held_month;
  int        held_year;
  int        result_idx;

  // gregorian leap rule, four-century exception included
  function automatic bit leap_year(input int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int month_length(input int m, input int y);
    if (m == gdate_pkg::MONTH_FEB) begin
      return leap_year(y) ? 29 : 28;
    end
    if (m == 4 || m == 6 || m == 9 || m == 11) begin
      return 30;
    end
    return 31;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  // apply one accepted item to the held date and queue the date it should produce
  task automatic advance_date(input logic [gdate_pkg::MODE_W-1:0] md, input int ld,
                              input int lm, input int ly, input int off);
    int        d;
    int        m;
    int        y;
    int        rem;
    bit        ovf;
    date_res_t r;
    ovf = 1'b0;
    case (md)
      gdate_pkg::MODE_LOAD: begin
        // out-of-range fields are clamped, month and year first
        m = (lm < gdate_pkg::MONTH_JAN) ? gdate_pkg::MONTH_JAN :
            (lm > gdate_pkg::MONTH_DEC) ? gdate_pkg::MONTH_DEC : lm;
        y = (ly < 1) ? 1 : (ly > LAST_YEAR) ? LAST_YEAR : ly;
        d = (ld < 1) ? 1 : ld;
        if (d > month_length(m, y)) d = month_length(m, y);
        held_day   = d;
        held_month = m;
        held_year  = y;
      end
      gdate_pkg::MODE_ADD: begin
        rem = held_day + off;
        m   = held_month;
        y   = held_year;
        while (!ovf && rem > month_length(m, y)) begin
          rem -= month_length(m, y);
          m++;
          if (m > gdate_pkg::MONTH_DEC) begin
            m = gdate_pkg::MONTH_JAN;
            y++;
            if (y > LAST_YEAR) ovf = 1'b1;
          end
        end
        if (!ovf) begin
          held_day   = rem;
          held_month = m;
          held_year  = y;
        end
      end
      gdate_pkg::MODE_SUB: begin
        rem = held_day - off;
        m   = held_month;
        y   = held_year;
        while (!ovf && rem < 1) begin
          m--;
          if (m == 0) begin
            m = gdate_pkg::MONTH_DEC;
            if (y <= 1) ovf = 1'b1;
            else y--;
          end
          if (!ovf) rem += month_length(m, y);
        end
        if (!ovf) begin
          held_day   = rem;
          held_month = m;
          held_year  = y;
        end
      end
      default: begin
        // unused mode leaves the date alone
      end
    endcase
    r.day   = held_day[gdate_pkg::DAY_W-1:0];
    r.month = held_month[gdate_pkg::MONTH_W-1:0];
    r.year  = held_year[gdate_pkg::YEAR_W-1:0];
    r.leap  = leap_year(held_year);
    r.ovf   = ovf;
    expected_dates.push_back(r);
  endtask

  // compare an arriving date with the oldest prediction
  task automatic check_result();
    date_res_t want;
    if (expected_dates.size() == 0) begin
      report_mismatch($sformatf("date %0d/%0d/%0d arrived with none expected",
                                cur_day, cur_month, cur_year));
    end else begin
      want = expected_dates.pop_front();
      if (cur_day !== want.day)
        report_mismatch($sformatf("item %0d day: got %0d, expected %0d",
                                  result_idx, cur_day, want.day));
      if (cur_month !== want.month)
        report_mismatch($sformatf("item %0d month: got %0d, expected %0d",
                                  result_idx, cur_month, want.month));
      if (cur_year !== want.year)
        report_mismatch($sformatf("item %0d year: got %0d, expected %0d",
                                  result_idx, cur_year, want.year));
      if (is_leap !== want.leap)
        report_mismatch($sformatf("item %0d leap flag: got %0b, expected %0b",
                                  result_idx, is_leap, want.leap));
      if (overflow !== want.ovf)
        report_mismatch($sformatf("item %0d overflow: got %0b, expected %0b",
                                  result_idx, overflow, want.ovf));
    end
    result_idx++;
  endtask

  // watch both channels on the rising edge; a result never belongs to the item taken with it
  always @(posedge clk) begin
    if (rst) begin
      held_day   = 1;
      held_month = 1;
      held_year  = 1;
      result_idx = 0;
      fail_count = 0;
      expected_dates.delete();
    end else begin
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready)
        advance_date(mode, int'(load_day), int'(load_month), int'(load_year),
                     int'(offset_days));
    end
    pending = expected_dates.size();
  end

endmodule

>>> verif/gregorian_date_add_subtract_days_top_tb.sv
// testbench top for the gregorian date block: clock, reset, stimulus phases and verdict
`timescale 1ns / 1ps

module gregorian_date_add_subtract_days_top_tb;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 5;
  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 2500;
  localparam int PHASE_ITEMS  = 50;

  // the one mode value the block leaves unused
  localparam logic [gdate_pkg::MODE_W-1:0] MODE_NONE = 2'd3;

  logic                                  clk = 1'b0;
  logic                                  rst;
  logic                                  in_valid;
  logic                                  in_ready;
  logic [gdate_pkg::MODE_W-1:0]          mode;
  logic [gdate_pkg::DAY_W-1:0]           load_day;
  logic [gdate_pkg::MONTH_W-1:0]         load_month;
  logic [gdate_pkg::YEAR_W-1:0]          load_year;
  logic [gdate_pkg::OFFSET_BITS_DEF-1:0] offset_days;
  logic                                  out_valid;
  logic                                  out_ready;
  logic [gdate_pkg::DAY_W-1:0]           cur_day;
  logic [gdate_pkg::MONTH_W-1:0]         cur_month;
  logic [gdate_pkg::YEAR_W-1:0]          cur_year;
  logic                                  is_leap;
  logic                                  overflow;

  int fail_count;
  int pending;
  int send_idle_pct;
  int stall_pct;
  int sent_count;
  bit hold_req;
  bit hold_done;

  gregorian_date_add_subtract_days_top dut (.*);

  gregorian_date_add_subtract_days_chk chk (.*);

  always #(CLK_PERIOD / 2) clk = ~clk;

  // receiver: random stalls, plus one long hold-off while the sender keeps offering
  initial begin
    out_ready = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // offer one item from a falling edge and return at the falling edge after it is taken
  task automatic send_date(input logic [gdate_pkg::MODE_W-1:0] md, input int d, input int m,
                           input int y, input int off);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    mode        <= md;
    load_day    <= d[gdate_pkg::DAY_W-1:0];
    load_month  <= m[gdate_pkg::MONTH_W-1:0];
    load_year   <= y[gdate_pkg::YEAR_W-1:0];
    offset_days <= off[gdate_pkg::OFFSET_BITS_DEF-1:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (md != MODE_NONE) sent_count++;
    @(negedge clk);
  endtask

  // mostly short moves, now and then one that spans decades
  function automatic int random_offset();
    int sel;
    sel = $urandom_range(99);
    if (sel < 70) return $urandom_range(400);
    if (sel < 92) return $urandom_range(4000, 401);
    return $urandom_range(65535);
  endfunction

  // years spread over the range, with weight on both ends of it
  function automatic int random_year();
    int sel;
    sel = $urandom_range(99);
    if (sel < 60) return $urandom_range(9999, 1);
    if (sel < 80) return $urandom_range(9999, 9995);
    return $urandom_range(3, 1);
  endfunction

  // add or subtract, load fields random since the block ignores them
  task automatic send_move(input int off);
    send_date($urandom_range(1) ? gdate_pkg::MODE_ADD : gdate_pkg::MODE_SUB,
              $urandom_range(31), $urandom_range(15), $urandom_range(16383), off);
  endtask

  task automatic send_load(input bit broken);
    int d;
    if (broken) begin
      send_date(gdate_pkg::MODE_LOAD, $urandom_range(31), $urandom_range(15),
                $urandom_range(16383), $urandom_range(65535));
    end else begin
      d = ($urandom_range(99) < 75) ? $urandom_range(28, 1) : $urandom_range(31, 29);
      send_date(gdate_pkg::MODE_LOAD, d, $urandom_range(12, 1), random_year(),
                $urandom_range(65535));
    end
  endtask

  // load-then-move sequences with some noise mixed in
  task automatic run_random(input int n_items);
    int target;
    int sel;
    int n_moves;
    target = sent_count + n_items;
    while (sent_count < target) begin
      sel = $urandom_range(99);
      if (sel < 80) begin
        send_load(1'b0);
        n_moves = $urandom_range(4, 1);
        repeat (n_moves) send_move(random_offset());
      end else if (sel < 88) begin
        send_date(MODE_NONE, $urandom_range(31), $urandom_range(15), $urandom_range(16383),
                  $urandom_range(65535));
      end else if (sel < 96) begin
        send_move(random_offset());
      end else begin
        send_load(1'b1);
      end
    end
  endtask

  // hard stop
  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("timeout: block stopped moving items");
    $display("FAIL");
    $finish;
  end

  initial begin
    in_valid      = 1'b0;
    mode          = gdate_pkg::MODE_LOAD;
    load_day      = '0;
    load_month    = '0;
    load_year     = '0;
    offset_days   = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    sent_count    = 0;
    hold_req      = 1'b0;
    rst           = 1'b1;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reset date, range ends, clamped loads, leap rules, month ends
    send_date(MODE_NONE, 31, 15, 16383, 65535);
    send_date(gdate_pkg::MODE_SUB, 0, 0, 0, 1);
    send_date(gdate_pkg::MODE_ADD, 0, 0, 0, 0);
    send_date(gdate_pkg::MODE_SUB, 0, 0, 0, 0);
    send_date(gdate_pkg::MODE_LOAD, 0, 0, 0, 0);
    send_date(gdate_pkg::MODE_LOAD, 31, 15, 16383, 65535);
    send_date(gdate_pkg::MODE_ADD, 31, 15, 16383, 1);
    send_date(gdate_pkg::MODE_SUB, 0, 0, 0, 65535);
    send_date(gdate_pkg::MODE_ADD, 0, 0, 0, 65535);
    send_date(gdate_pkg::MODE_LOAD, 29, 2, 2000, 0);
    send_date(gdate_pkg::MODE_ADD, 0, 0, 0, 365);
    send_date(gdate_pkg::MODE_LOAD, 29, 2, 1900, 0);
    send_date(gdate_pkg::MODE_LOAD, 31, 4, 2023, 0);
    send_date(gdate_pkg::MODE_LOAD, 31, 1, 2023, 0);
    send_date(gdate_pkg::MODE_ADD, 0, 0, 0, 28);
    send_date(gdate_pkg::MODE_SUB, 0, 0, 0, 28);
    send_date(gdate_pkg::MODE_LOAD, 28, 2, 2024, 0);
    send_date(gdate_pkg::MODE_ADD, 0, 0, 0, 1);
    send_date(gdate_pkg::MODE_ADD, 0, 0, 0, 1);
    send_date(gdate_pkg::MODE_LOAD, 1, 1, 2, 0);
    send_date(gdate_pkg::MODE_SUB, 0, 0, 0, 365);
    send_date(gdate_pkg::MODE_SUB, 0, 0, 0, 1);
    send_date(gdate_pkg::MODE_LOAD, 31, 12, 9998, 0);
    send_date(gdate_pkg::MODE_ADD, 0, 0, 0, 365);
    send_date(gdate_pkg::MODE_ADD, 0, 0, 0, 1);
    send_date(gdate_pkg::MODE_LOAD, 1, 1, 5000, 0);
    send_date(gdate_pkg::MODE_ADD, 0, 0, 0, 32768);
    send_date(gdate_pkg::MODE_SUB, 0, 0, 0, 32768);

    // random phases with different idling on each side
    run_random(PHASE_ITEMS);
    send_idle_pct = 77;
    run_random(PHASE_ITEMS);
    send_idle_pct = 0;
    stall_pct     = 77;
    run_random(PHASE_ITEMS);
    send_idle_pct = 14;
    stall_pct     = 14;
    run_random(PHASE_ITEMS);

    // receiver holds off while short moves keep coming, so the input backs up
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = 1'b1;
    send_load(1'b0);
    repeat (11) send_move($urandom_range(60));
    in_valid <= 1'b0;

    // drain, then give any stray result time to show up
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
